FILE: src/lzw_variable_width_decoder_macros.svh
// Assertion helpers for the LZW decoder.
`ifndef LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH
`define LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH

// same-cycle implication
`define LZWD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZWD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lzwd_pkg.sv
package lzwd_pkg;

  localparam int MaxCodeBits = 12;
  localparam int DictDepth   = 1 << MaxCodeBits;
  localparam int DepthW      = MaxCodeBits + 1;

  localparam logic [DepthW-1:0] FirstFree = DepthW'(259);
  localparam logic [4:0]        InitWidth = 5'd9;
  localparam logic [5:0]        FeedLimit = 6'd24;

  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdFeed  = 2'd1;
  localparam logic [1:0] CmdPull  = 2'd2;

  localparam logic [MaxCodeBits-1:0] CodeClear = '0;
  localparam logic [MaxCodeBits-1:0] CodeError = MaxCodeBits'(1);
  localparam logic [MaxCodeBits-1:0] CodeEnd   = MaxCodeBits'(2);

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatBadCode = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;

  typedef struct packed {
    logic clear;
    logic feed;
    logic take;
    logic align;
  } bb_cmd_t;

endpackage

FILE: src/lzwd_bitbuf.sv
module lzwd_bitbuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lzwd_pkg::bb_cmd_t             cmd_i,
  input  logic [7:0]                    byte_i,
  input  logic [4:0]                    width_i,
  output logic [lzwd_pkg::MaxCodeBits-1:0] code_o,
  output logic [5:0]                    count_o
);
  import lzwd_pkg::*;

  logic [31:0] shreg_q, shreg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [2:0]  phase_q, phase_d;

  logic [5:0]  sh;
  logic [31:0] shifted;
  logic [5:0]  skip_n, skip_c, cnt_al;

  assign sh      = cnt_q - {1'b0, width_i};
  assign shifted = shreg_q >> sh;
  assign code_o  = shifted[MaxCodeBits-1:0];
  assign count_o = cnt_q;

  assign skip_n = 6'd8 - {3'b000, phase_q};
  assign skip_c = (skip_n > cnt_q) ? cnt_q : skip_n;
  assign cnt_al = cnt_q - skip_c;

  always_comb begin
    shreg_d = shreg_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (cmd_i.clear) begin
      shreg_d = '0;
      cnt_d   = '0;
      phase_d = '0;
    end else if (cmd_i.feed) begin
      shreg_d = {shreg_q[23:0], byte_i};
      cnt_d   = cnt_q + 6'd8;
    end else if (cmd_i.take) begin
      shreg_d = shreg_q & ((32'h1 << sh) - 32'h1);
      cnt_d   = sh;
      phase_d = phase_q + width_i[2:0];
    end else if (cmd_i.align) begin
      if (phase_q != 3'd0) begin
        shreg_d = shreg_q & ((32'h1 << cnt_al) - 32'h1);
        cnt_d   = cnt_al;
      end
      phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shreg_q <= '0;
      cnt_q   <= '0;
      phase_q <= '0;
    end else begin
      shreg_q <= shreg_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: src/lzw_variable_width_decoder.sv
// LZW decoder, codes packed MSB first, 9 bits wide at start and widened by
// the clear code up to 12 bits. One beat goes in, one result beat comes
// out. Start, feed and unused commands answer straight from idle. A pull
// walks the parent chain of a code through the dictionary memory onto a
// stack, then pops one byte per pull: a pull served from the stack passes
// the loop, pop and response states; one that decodes a new code also walks
// the chain first, and each clear code met adds a skip state. The dictionary
// read port sets the walking rate. No clearing pass after reset.
module lzw_variable_width_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       accepted_o,
  output logic       need_input_o,
  output logic       end_of_stream_o,
  output logic [1:0] status_o
);
  import lzwd_pkg::*;

  typedef enum logic [7:0] {
    StIdle = 8'b00000001,
    StLoop = 8'b00000010,
    StSkip = 8'b00000100,
    StWrd  = 8'b00001000,
    StWwr  = 8'b00010000,
    StFix  = 8'b00100000,
    StPop  = 8'b01000000,
    StResp = 8'b10000000
  } state_e;

  localparam int Aw = MaxCodeBits;

  state_e           state_q, state_d;
  logic [4:0]       width_q, width_d;
  logic [DepthW-1:0] nf_q, nf_d;
  logic [Aw-1:0]    prev_q, prev_d;
  logic             first_q, first_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic             done_q, done_d;
  logic [Aw-1:0]    cur_q, cur_d;
  logic [Aw-1:0]    code_q, code_d;
  logic             kwk_q, kwk_d;
  logic             learn_q, learn_d;
  logic [7:0]       root_q, root_d;
  logic             hit_q, hit_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             ovb_q, ovb_d;
  logic             acc_q, acc_d;
  logic             need_q, need_d;
  logic             eos_q, eos_d;
  logic [1:0]       stat_q, stat_d;

  bb_cmd_t          bb_cmd;
  logic [Aw-1:0]    bb_code;
  logic [5:0]       bb_count;

  logic [7:0]       dict_byte_mem [DictDepth];
  logic [Aw-1:0]    dict_par_mem [DictDepth];
  logic [7:0]       stack_mem [DictDepth];
  logic [7:0]       rd_byte_q;
  logic [Aw-1:0]    rd_par_q;
  logic [7:0]       stk_rd_q;

  logic             dict_re, dict_we;
  logic             stk_we, stk_re;
  logic [Aw-1:0]    stk_waddr, stk_raddr;
  logic [7:0]       stk_wdata;

  logic             accept;
  logic             literal;
  logic [7:0]       lit_byte;
  logic             code_kwk;
  logic [DepthW-1:0] depth_dec;

  assign in_ready_o = (state_q == StIdle) && !ovalid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign literal    = {1'b0, cur_q} < FirstFree;
  assign lit_byte   = cur_q[7:0] - 8'd3;
  assign code_kwk   = {1'b0, bb_code} >= nf_q;
  assign depth_dec  = depth_q - DepthW'(1);

  lzwd_bitbuf u_bitbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (bb_cmd),
    .byte_i  (in_byte_i),
    .width_i (width_q),
    .code_o  (bb_code),
    .count_o (bb_count)
  );

  always_comb begin
    state_d  = state_q;
    width_d  = width_q;
    nf_d     = nf_q;
    prev_d   = prev_q;
    first_d  = first_q;
    depth_d  = depth_q;
    done_d   = done_q;
    cur_d    = cur_q;
    code_d   = code_q;
    kwk_d    = kwk_q;
    learn_d  = learn_q;
    root_d   = root_q;
    hit_d    = hit_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    ovb_d    = ovb_q;
    acc_d    = acc_q;
    need_d   = need_q;
    eos_d    = eos_q;
    stat_d   = stat_q;
    bb_cmd   = '0;
    dict_re  = 1'b0;
    dict_we  = 1'b0;
    stk_we   = 1'b0;
    stk_re   = 1'b0;
    stk_waddr = depth_q[Aw-1:0];
    stk_wdata = lit_byte;
    stk_raddr = depth_dec[Aw-1:0];

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          obyte_d = '0;
          ovb_d   = 1'b0;
          acc_d   = 1'b0;
          need_d  = 1'b0;
          eos_d   = 1'b0;
          stat_d  = StatOk;
          hit_d   = 1'b0;
          case (cmd_i)
            CmdStart: begin
              bb_cmd.clear = 1'b1;
              width_d  = InitWidth;
              nf_d     = FirstFree;
              prev_d   = '0;
              first_d  = 1'b1;
              depth_d  = '0;
              done_d   = 1'b0;
              ovalid_d = 1'b1;
            end
            CmdFeed: begin
              if (!done_q && bb_count <= FeedLimit) begin
                bb_cmd.feed = 1'b1;
                acc_d       = 1'b1;
              end
              ovalid_d = 1'b1;
            end
            CmdPull: state_d = StLoop;
            default: ovalid_d = 1'b1;
          endcase
        end
      end
      StLoop: begin
        if (depth_q != '0 || done_q) begin
          state_d = StPop;
        end else if (bb_count < {1'b0, width_q}) begin
          need_d  = 1'b1;
          state_d = StPop;
        end else begin
          bb_cmd.take = 1'b1;
          unique case (bb_code)
            CodeClear: begin
              if (width_q < 5'(MaxCodeBits)) width_d = width_q + 5'd1;
              state_d = StSkip;
            end
            CodeError: begin
              stat_d  = StatBadCode;
              state_d = StPop;
            end
            CodeEnd: begin
              done_d  = 1'b1;
              state_d = StPop;
            end
            default: begin
              if (first_q) begin
                if (code_kwk) begin
                  stat_d  = StatBadCode;
                  state_d = StPop;
                end else begin
                  cur_d   = bb_code;
                  prev_d  = bb_code;
                  first_d = 1'b0;
                  learn_d = 1'b0;
                  depth_d = '0;
                  state_d = StWrd;
                end
              end else begin
                kwk_d   = code_kwk;
                code_d  = bb_code;
                cur_d   = code_kwk ? prev_q : bb_code;
                depth_d = code_kwk ? DepthW'(1) : '0;
                learn_d = 1'b1;
                state_d = StWrd;
              end
            end
          endcase
        end
      end
      StSkip: begin
        bb_cmd.align = 1'b1;
        state_d      = StLoop;
      end
      StWrd: begin
        if (literal) begin
          stk_we  = 1'b1;
          depth_d = depth_q + DepthW'(1);
          root_d  = lit_byte;
          state_d = learn_q ? StFix : StPop;
        end else begin
          dict_re = 1'b1;
          state_d = StWwr;
        end
      end
      StWwr: begin
        stk_we    = 1'b1;
        stk_wdata = rd_byte_q;
        depth_d   = depth_q + DepthW'(1);
        cur_d     = rd_par_q;
        state_d   = StWrd;
      end
      StFix: begin
        if (kwk_q) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = root_q;
        end
        if (nf_q < DepthW'(DictDepth)) begin
          dict_we = 1'b1;
          nf_d    = nf_q + DepthW'(1);
          prev_d  = kwk_q ? nf_q[Aw-1:0] : code_q;
        end else begin
          stat_d = StatFull;
          prev_d = kwk_q ? prev_q : code_q;
        end
        state_d = StPop;
      end
      StPop: begin
        if (depth_q != '0) begin
          stk_re  = 1'b1;
          depth_d = depth_dec;
          hit_d   = 1'b1;
          eos_d   = done_q && (depth_dec == '0);
        end else begin
          eos_d = done_q;
        end
        state_d = StResp;
      end
      StResp: begin
        obyte_d  = hit_q ? stk_rd_q : 8'd0;
        ovb_d    = hit_q;
        ovalid_d = 1'b1;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dict_re) begin
      rd_byte_q <= dict_byte_mem[cur_q];
      rd_par_q  <= dict_par_mem[cur_q];
    end
    if (dict_we) begin
      dict_byte_mem[nf_q[Aw-1:0]] <= root_q;
      dict_par_mem[nf_q[Aw-1:0]]  <= prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      width_q  <= InitWidth;
      nf_q     <= FirstFree;
      prev_q   <= '0;
      first_q  <= 1'b1;
      depth_q  <= '0;
      done_q   <= 1'b0;
      kwk_q    <= 1'b0;
      learn_q  <= 1'b0;
      hit_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      width_q  <= width_d;
      nf_q     <= nf_d;
      prev_q   <= prev_d;
      first_q  <= first_d;
      depth_q  <= depth_d;
      done_q   <= done_d;
      kwk_q    <= kwk_d;
      learn_q  <= learn_d;
      hit_q    <= hit_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    code_q  <= code_d;
    root_q  <= root_d;
    obyte_q <= obyte_d;
    ovb_q   <= ovb_d;
    acc_q   <= acc_d;
    need_q  <= need_d;
    eos_q   <= eos_d;
    stat_q  <= stat_d;
  end

  assign out_valid_o     = ovalid_q;
  assign out_byte_o      = obyte_q;
  assign byte_valid_o    = ovb_q;
  assign accepted_o      = acc_q;
  assign need_input_o    = need_q;
  assign end_of_stream_o = eos_q;
  assign status_o        = stat_q;

`include "lzw_variable_width_decoder_macros.svh"

  `LZWD_ASSERT_IMP(a_ready_excl, in_ready_o, !out_valid_o, "ready while result pending")
  `LZWD_ASSERT_IMP(a_stack_after_first, depth_q != '0, !first_q, "stack holds bytes before first code")
  `LZWD_ASSERT_IMP(a_bits_bound, 1'b1, bb_count <= 6'd32, "bit buffer overfilled")
  `LZWD_ASSERT_NXT(a_pull_start, accept && cmd_i == CmdPull, state_q == StLoop, "pull not started")

endmodule
